// ===== design/perfect_hash_key_lookup_assert.svh =====
// assertion macros for the perfect hash key lookup
// used by perfect_hash_key_lookup.sv, expects aclk and aresetn in scope
`ifndef PERFECT_HASH_KEY_LOOKUP_ASSERT_SVH
`define PERFECT_HASH_KEY_LOOKUP_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define PHKL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("phkl: same-cycle check failed");
// next-cycle implication
`define PHKL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("phkl: next-cycle check failed");
`else
`define PHKL_ASSERT_NOW(label, ante, cons)
`define PHKL_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== design/phkl_pkg.sv =====
// constants, types and arithmetic helpers for the perfect hash key lookup
// no dependencies
package phkl_pkg;

    localparam int CLASS_COUNT = 64;
    localparam int COLUMN_MAX  = 16;
    localparam int VERTEX_MAX  = 4096;

    localparam int CLASS_BITS  = $clog2(CLASS_COUNT);
    localparam int COL_BITS    = $clog2(COLUMN_MAX);
    localparam int VTX_BITS    = $clog2(VERTEX_MAX);
    localparam int WT_ADDR_BITS = CLASS_BITS + COL_BITS;
    localparam int LEN_BITS    = 8;

    typedef logic [VTX_BITS-1:0] vertex_t;
    typedef logic [VTX_BITS:0]   count_t;
    typedef logic [COL_BITS-1:0] column_t;
    typedef logic [4:0]          col_cnt_t;

    // input kinds
    localparam logic [1:0] KIND_CHAR   = 2'd0;
    localparam logic [1:0] KIND_CLASS  = 2'd1;
    localparam logic [1:0] KIND_WEIGHT = 2'd2;
    localparam logic [1:0] KIND_VERTEX = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_VERTEX_COUNT = 2'd0;
    localparam logic [1:0] CFG_KEY_LIMIT    = 2'd1;
    localparam logic [1:0] CFG_COLUMN_COUNT = 2'd2;

    // sum with one conditional subtraction, wraps at register width
    function automatic vertex_t add_mod(vertex_t s, vertex_t w, count_t n);
        count_t t;
        t = {1'b0, s} + {1'b0, w};
        if (t >= n) t = t - n;
        return t[VTX_BITS-1:0];
    endfunction

    // increment with wrap to zero at n
    function automatic vertex_t bump(vertex_t x, count_t n);
        count_t t;
        t = {1'b0, x} + count_t'(1);
        return (t >= n) ? vertex_t'(0) : t[VTX_BITS-1:0];
    endfunction

endpackage

// ===== design/perfect_hash_key_lookup.sv =====
// perfect hash key lookup on a three-vertex hypergraph, single module
// depends on phkl_pkg and perfect_hash_key_lookup_assert.svh
//
// load transactions are taken in idle; a non-first key character takes a class read,
// then a weight read, with its sums folded in on the next idle cycle; a first
// character first runs the 8-step bit-serial remainder of (length-1) by the
// column count; the result is registered after the last character's sums are
// folded in and the three g reads on one port (ST_SEP, ST_G1, ST_G2, then ST_G3);
// input resumes as the result is registered, which waits while an older one is held
// synchronous active-low reset clears control state and sums and presets the
// configuration registers; tables are not cleared and must be loaded before use
`include "perfect_hash_key_lookup_assert.svh"

module perfect_hash_key_lookup (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_wdata,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [7:0]  s_char_value,
    input  logic [7:0]  s_key_length,
    input  logic [5:0]  s_class_value,
    input  logic [5:0]  s_table_row,
    input  logic [3:0]  s_table_column,
    input  logic [11:0] s_weight_a,
    input  logic [11:0] s_weight_b,
    input  logic [11:0] s_weight_c,
    input  logic [11:0] s_vertex_index,
    input  logic [11:0] s_g_value,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [11:0] m_hash_value,
    output logic        m_over_limit
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_WRD,
        ST_SEP,
        ST_G1,
        ST_G2,
        ST_G3
    } state_t;

    state_t state_reg;

    // configuration registers
    phkl_pkg::count_t   vertex_count_reg;
    logic [11:0]        key_limit_reg;
    phkl_pkg::col_cnt_t column_count_reg;

    // key state
    phkl_pkg::vertex_t  sum_first_reg, sum_second_reg, sum_third_reg;
    phkl_pkg::column_t  column_pointer_reg;
    logic [7:0]         chars_left_reg;
    logic               pend_reg;      // weight read done, sums not yet folded in

    // bit-serial remainder for the start column
    logic [7:0]         div_reg;
    logic [3:0]         rem_reg;
    logic [2:0]         div_cnt_reg;

    // separated vertices and g accumulator
    phkl_pkg::vertex_t  vtx_b_reg, vtx_c_reg;
    logic [11:0]        x_reg;

    // result register
    logic               m_valid_reg;
    logic [11:0]        hash_reg;
    logic               over_reg;

    // memories
    logic [phkl_pkg::CLASS_BITS-1:0] class_mem [256];
    logic [35:0]        weight_mem [phkl_pkg::CLASS_COUNT*phkl_pkg::COLUMN_MAX];
    logic [11:0]        g_mem [phkl_pkg::VERTEX_MAX];

    logic [phkl_pkg::CLASS_BITS-1:0] cls_rdata_reg;
    logic [35:0]        wt_rdata_reg;
    logic [11:0]        g_rdata_reg;

    logic               s_accept;
    logic               last_pending;
    phkl_pkg::count_t   n_eff;
    phkl_pkg::col_cnt_t cols_eff;
    phkl_pkg::vertex_t  upd_first, upd_second, upd_third;
    phkl_pkg::column_t  cp_adv;
    logic [4:0]         trial, trial_sub;
    logic [7:0]         len_eff;
    phkl_pkg::vertex_t  v_sep, w_sep, w_step;
    phkl_pkg::vertex_t  g_raddr;
    logic               g_re;
    logic [11:0]        x_final;
    logic               res_load;

    assign last_pending = pend_reg && (chars_left_reg == 8'd1);
    // one transaction at a time; the last character of a key blocks until its sums land
    assign s_ready  = (state_reg == ST_IDLE) && !last_pending;
    assign s_accept = s_valid && s_ready;

    assign m_valid      = m_valid_reg;
    assign m_hash_value = hash_reg;
    assign m_over_limit = over_reg;

    // result register takes the new hash once the old one has gone
    assign res_load = (state_reg == ST_G3) && (!m_valid_reg || m_ready);

    // effective modulus and table width, out-of-range values clamped
    always_comb begin
        if (vertex_count_reg == '0) begin
            n_eff = phkl_pkg::count_t'(1);
        end else if (vertex_count_reg > phkl_pkg::count_t'(phkl_pkg::VERTEX_MAX)) begin
            n_eff = phkl_pkg::count_t'(phkl_pkg::VERTEX_MAX);
        end else begin
            n_eff = vertex_count_reg;
        end
        if (column_count_reg == '0) begin
            cols_eff = phkl_pkg::col_cnt_t'(1);
        end else if (column_count_reg > phkl_pkg::col_cnt_t'(phkl_pkg::COLUMN_MAX)) begin
            cols_eff = phkl_pkg::col_cnt_t'(phkl_pkg::COLUMN_MAX);
        end else begin
            cols_eff = column_count_reg;
        end
    end

    // sum update from the weight triple read for the current character
    always_comb begin
        logic [4:0] cp_inc;
        cp_inc     = {1'b0, column_pointer_reg} + 5'd1;
        upd_first  = phkl_pkg::add_mod(sum_first_reg,  wt_rdata_reg[35:24], n_eff);
        upd_second = phkl_pkg::add_mod(sum_second_reg, wt_rdata_reg[23:12], n_eff);
        upd_third  = phkl_pkg::add_mod(sum_third_reg,  wt_rdata_reg[11:0],  n_eff);
        cp_adv     = (cp_inc >= cols_eff) ? '0 : cp_inc[phkl_pkg::COL_BITS-1:0];
    end

    // one restoring step of (length-1) mod columns
    assign trial     = {rem_reg, div_reg[7]};
    assign trial_sub = (trial >= cols_eff) ? (trial - cols_eff) : trial;
    assign len_eff   = (s_key_length == 8'd0) ? 8'd1 : s_key_length;

    // move equal vertices apart, with wrap
    always_comb begin
        v_sep = (sum_first_reg == sum_second_reg) ?
                phkl_pkg::bump(sum_second_reg, n_eff) : sum_second_reg;
        w_step = phkl_pkg::bump(sum_third_reg, n_eff);
        if (sum_third_reg == v_sep) begin
            w_sep = (w_step == sum_first_reg) ? phkl_pkg::bump(w_step, n_eff) : w_step;
        end else if (sum_third_reg == sum_first_reg) begin
            w_sep = (w_step == v_sep) ? phkl_pkg::bump(w_step, n_eff) : w_step;
        end else begin
            w_sep = sum_third_reg;
        end
    end

    // g read address: first vertex, then second, then third
    always_comb begin
        case (state_reg)
            ST_SEP:  g_raddr = sum_first_reg;
            ST_G1:   g_raddr = vtx_b_reg;
            default: g_raddr = vtx_c_reg;
        endcase
    end
    assign g_re    = (state_reg == ST_SEP) || (state_reg == ST_G1) || (state_reg == ST_G2);
    assign x_final = x_reg ^ g_rdata_reg;

    // class translate table
    always_ff @(posedge aclk) begin
        if (s_accept && (s_kind == phkl_pkg::KIND_CLASS)) begin
            class_mem[s_char_value] <= s_class_value;
        end
        if (s_accept && (s_kind == phkl_pkg::KIND_CHAR)) begin
            cls_rdata_reg <= class_mem[s_char_value];
        end
    end

    // weight triple table, row-major by class then column
    always_ff @(posedge aclk) begin
        if (s_accept && (s_kind == phkl_pkg::KIND_WEIGHT)) begin
            weight_mem[{s_table_row, s_table_column}] <= {s_weight_a, s_weight_b, s_weight_c};
        end
        if (state_reg == ST_WRD) begin
            wt_rdata_reg <= weight_mem[{cls_rdata_reg, column_pointer_reg}];
        end
    end

    // vertex value table g
    always_ff @(posedge aclk) begin
        if (s_accept && (s_kind == phkl_pkg::KIND_VERTEX)) begin
            g_mem[s_vertex_index] <= s_g_value;
        end
        if (g_re) begin
            g_rdata_reg <= g_mem[g_raddr];
        end
    end

    // state machine, key state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            vertex_count_reg   <= phkl_pkg::count_t'(phkl_pkg::VERTEX_MAX);
            key_limit_reg      <= 12'hFFF;
            column_count_reg   <= phkl_pkg::col_cnt_t'(1);
            sum_first_reg      <= '0;
            sum_second_reg     <= '0;
            sum_third_reg      <= '0;
            column_pointer_reg <= '0;
            chars_left_reg     <= '0;
            pend_reg           <= 1'b0;
            div_cnt_reg        <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    phkl_pkg::CFG_VERTEX_COUNT: vertex_count_reg <= cfg_wdata;
                    phkl_pkg::CFG_KEY_LIMIT:    key_limit_reg    <= cfg_wdata[11:0];
                    phkl_pkg::CFG_COLUMN_COUNT: column_count_reg <= cfg_wdata[4:0];
                    default: ;
                endcase
            end

            if (res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    // fold in the previous character's weights
                    if (pend_reg) begin
                        sum_first_reg      <= upd_first;
                        sum_second_reg     <= upd_second;
                        sum_third_reg      <= upd_third;
                        column_pointer_reg <= cp_adv;
                        chars_left_reg     <= chars_left_reg - 8'd1;
                        pend_reg           <= 1'b0;
                        if (last_pending) begin
                            state_reg <= ST_SEP;
                        end
                    end
                    if (s_accept && (s_kind == phkl_pkg::KIND_CHAR)) begin
                        if (!pend_reg && (chars_left_reg == 8'd0)) begin
                            // first character of a key
                            chars_left_reg <= len_eff;
                            sum_first_reg  <= '0;
                            sum_second_reg <= '0;
                            sum_third_reg  <= '0;
                            div_reg        <= len_eff - 8'd1;
                            rem_reg        <= '0;
                            div_cnt_reg    <= '0;
                            state_reg      <= ST_MOD;
                        end else begin
                            state_reg <= ST_WRD;
                        end
                    end
                end
                ST_MOD: begin
                    rem_reg     <= trial_sub[3:0];
                    div_reg     <= {div_reg[6:0], 1'b0};
                    div_cnt_reg <= div_cnt_reg + 3'd1;
                    if (div_cnt_reg == 3'd7) begin
                        column_pointer_reg <= trial_sub[phkl_pkg::COL_BITS-1:0];
                        state_reg          <= ST_WRD;
                    end
                end
                ST_WRD: begin
                    pend_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                ST_SEP: begin
                    vtx_b_reg <= v_sep;
                    vtx_c_reg <= w_sep;
                    state_reg <= ST_G1;
                end
                ST_G1: begin
                    x_reg     <= g_rdata_reg;
                    state_reg <= ST_G2;
                end
                ST_G2: begin
                    x_reg     <= x_final;
                    state_reg <= ST_G3;
                end
                ST_G3: begin
                    // wait here while the previous result is still held
                    if (res_load) begin
                        if (x_final > key_limit_reg) begin
                            hash_reg <= '0;
                            over_reg <= 1'b1;
                        end else begin
                            hash_reg <= x_final;
                            over_reg <= 1'b0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // a flagged result always carries zero
    `PHKL_ASSERT_NOW(a_over_zero, m_valid_reg && over_reg, hash_reg == 12'd0)
    // folding of sums only happens in idle
    `PHKL_ASSERT_NOW(a_pend_idle, pend_reg, state_reg == ST_IDLE)
    // the start column is only worked out for a key in progress
    `PHKL_ASSERT_NOW(a_mod_key, state_reg == ST_MOD, chars_left_reg != 8'd0)
    // separation follows only the last character's sum update
    `PHKL_ASSERT_NEXT(a_last_sep, last_pending && (state_reg == ST_IDLE), state_reg == ST_SEP)

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for perfect_hash_key_lookup: table loads and key streams
// depend on phkl_pkg for kinds and register indexes; the scoreboard class lives here

module tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int ITEM_TARGET    = 750;
    localparam int NUM_PHASES     = 8;
    localparam int WT_SLOTS       = phkl_pkg::CLASS_COUNT * phkl_pkg::COLUMN_MAX;

    // one input transaction, every field as on the port
    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  char_value;
        logic [7:0]  key_length;
        logic [5:0]  class_value;
        logic [5:0]  table_row;
        logic [3:0]  table_column;
        logic [11:0] weight_a;
        logic [11:0] weight_b;
        logic [11:0] weight_c;
        logic [11:0] vertex_index;
        logic [11:0] g_value;
    } txn_t;

    typedef struct {
        logic [11:0] hash_value;
        logic        over_limit;
    } hash_out_t;

    // running sums of the key being hashed
    typedef struct {
        phkl_pkg::vertex_t sum_a;
        phkl_pkg::vertex_t sum_b;
        phkl_pkg::vertex_t sum_c;
        phkl_pkg::column_t column;
        logic [7:0]        left;
    } key_progress_t;

    // hash predictor and queue of hashes still owed by the block
    class hash_scoreboard;
        logic [5:0]  char_class [256];
        logic [11:0] wt_a [WT_SLOTS];
        logic [11:0] wt_b [WT_SLOTS];
        logic [11:0] wt_c [WT_SLOTS];
        logic [11:0] g_tab [phkl_pkg::VERTEX_MAX];
        bit          class_set [256];
        bit          weight_set [WT_SLOTS];
        bit          g_set [phkl_pkg::VERTEX_MAX];
        key_progress_t prog;
        logic [12:0] vertex_count = 13'd4096;
        logic [11:0] key_limit    = 12'd4095;
        logic [4:0]  column_count = 5'd1;
        hash_out_t   hash_q [$];
        int          errors = 0;

        function new();
            prog = '{default: '0};
        endfunction

        function void write_reg(logic [1:0] idx, logic [12:0] val);
            case (idx)
                phkl_pkg::CFG_VERTEX_COUNT: vertex_count = val;
                phkl_pkg::CFG_KEY_LIMIT:    key_limit    = val[11:0];
                phkl_pkg::CFG_COLUMN_COUNT: column_count = val[4:0];
                default: ;
            endcase
        endfunction

        function logic [12:0] modulus();
            if (vertex_count == 0) return 13'd1;
            if (vertex_count > phkl_pkg::VERTEX_MAX) return 13'(phkl_pkg::VERTEX_MAX);
            return vertex_count;
        endfunction

        function logic [4:0] width_cols();
            if (column_count == 0) return 5'd1;
            if (column_count > phkl_pkg::COLUMN_MAX) return 5'(phkl_pkg::COLUMN_MAX);
            return column_count;
        endfunction

        function int wt_slot(logic [5:0] row, logic [3:0] col);
            return int'(row) * phkl_pkg::COLUMN_MAX + int'(col);
        endfunction

        function phkl_pkg::column_t first_column(logic [7:0] len);
            int l;
            l = (len == 0) ? 1 : int'(len);
            return phkl_pkg::column_t'((l - 1) % int'(width_cols()));
        endfunction

        // one subtraction only, so a weight at or above n leaves the sum wrapping
        function phkl_pkg::vertex_t fold_weight(phkl_pkg::vertex_t s, logic [11:0] w,
                                                logic [12:0] n);
            logic [12:0] t;
            t = {1'b0, s} + {1'b0, w};
            if (t >= n) t = t - n;
            return t[11:0];
        endfunction

        function phkl_pkg::vertex_t step_vertex(phkl_pkg::vertex_t x, logic [12:0] n);
            logic [12:0] t;
            t = {1'b0, x} + 13'd1;
            return (t >= n) ? phkl_pkg::vertex_t'(0) : t[11:0];
        endfunction

        // folds one key character into k, returns 1 when the key is complete
        function bit advance(inout key_progress_t k, input logic [7:0] ch,
                             input logic [7:0] len);
            logic [12:0] n;
            logic [4:0]  cols;
            int          slot;
            n    = modulus();
            cols = width_cols();
            if (k.left == 0) begin
                k.left   = (len == 0) ? 8'd1 : len;
                k.column = first_column(len);
                k.sum_a  = '0;
                k.sum_b  = '0;
                k.sum_c  = '0;
            end
            slot    = wt_slot(char_class[ch], k.column);
            k.sum_a = fold_weight(k.sum_a, wt_a[slot], n);
            k.sum_b = fold_weight(k.sum_b, wt_b[slot], n);
            k.sum_c = fold_weight(k.sum_c, wt_c[slot], n);
            if ({1'b0, k.column} + 5'd1 >= cols) k.column = '0;
            else k.column = k.column + 4'd1;
            k.left = k.left - 8'd1;
            return k.left == 0;
        endfunction

        // pushes equal vertices apart
        function void spread(key_progress_t k, output phkl_pkg::vertex_t u,
                             output phkl_pkg::vertex_t v, output phkl_pkg::vertex_t w);
            logic [12:0] n;
            n = modulus();
            u = k.sum_a;
            v = k.sum_b;
            w = k.sum_c;
            if (u == v) v = step_vertex(v, n);
            if (w == v) begin
                w = step_vertex(w, n);
                if (w == u) w = step_vertex(w, n);
            end else if (w == u) begin
                w = step_vertex(w, n);
                if (w == v) w = step_vertex(w, n);
            end
        endfunction

        function void note_input(txn_t it);
            int                slot;
            phkl_pkg::vertex_t u, v, w;
            logic [11:0]       x;
            hash_out_t         h;
            case (it.kind)
                phkl_pkg::KIND_CLASS: begin
                    char_class[it.char_value] = it.class_value;
                    class_set[it.char_value]  = 1'b1;
                end
                phkl_pkg::KIND_WEIGHT: begin
                    slot             = wt_slot(it.table_row, it.table_column);
                    wt_a[slot]       = it.weight_a;
                    wt_b[slot]       = it.weight_b;
                    wt_c[slot]       = it.weight_c;
                    weight_set[slot] = 1'b1;
                end
                phkl_pkg::KIND_VERTEX: begin
                    g_tab[it.vertex_index] = it.g_value;
                    g_set[it.vertex_index] = 1'b1;
                end
                default: begin
                    if (advance(prog, it.char_value, it.key_length)) begin
                        spread(prog, u, v, w);
                        x = g_tab[u] ^ g_tab[v] ^ g_tab[w];
                        if (x > key_limit) h = '{12'd0, 1'b1};
                        else h = '{x, 1'b0};
                        hash_q.push_back(h);
                    end
                end
            endcase
        endfunction

        function void check_result(logic [11:0] hv, logic ol);
            hash_out_t h;
            if (hash_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, actual hash %0h over_limit %0b",
                         $time, hv, ol);
                return;
            end
            h = hash_q.pop_front();
            if (hv !== h.hash_value) begin
                errors++;
                $display("%0t: hash_value mismatch, expected %0h, actual %0h",
                         $time, h.hash_value, hv);
            end
            if (ol !== h.over_limit) begin
                errors++;
                $display("%0t: over_limit mismatch, expected %0b, actual %0b",
                         $time, h.over_limit, ol);
            end
        endfunction

        function int pending();
            return hash_q.size();
        endfunction
    endclass

    // clock, reset and block ports; those the bench drives are known from time zero
    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        cfg_wr_en      = 1'b0;
    logic [1:0]  cfg_index      = phkl_pkg::CFG_VERTEX_COUNT;
    logic [12:0] cfg_wdata      = '0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [1:0]  s_kind         = phkl_pkg::KIND_CHAR;
    logic [7:0]  s_char_value   = '0;
    logic [7:0]  s_key_length   = '0;
    logic [5:0]  s_class_value  = '0;
    logic [5:0]  s_table_row    = '0;
    logic [3:0]  s_table_column = '0;
    logic [11:0] s_weight_a     = '0;
    logic [11:0] s_weight_b     = '0;
    logic [11:0] s_weight_c     = '0;
    logic [11:0] s_vertex_index = '0;
    logic [11:0] s_g_value      = '0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [11:0] m_hash_value;
    logic        m_over_limit;

    hash_scoreboard sb = new();

    int  sent_items  = 0;
    int  burst_left  = 4;
    bit  valid_up    = 1'b0;
    int  quiet_cycles = 0;
    int  ready_mode  = 0;
    int  mode_left   = 0;
    logic [2:0] rx_phase = '0;

    always #5 aclk = ~aclk;

    perfect_hash_key_lookup DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_char_value   (s_char_value),
        .s_key_length   (s_key_length),
        .s_class_value  (s_class_value),
        .s_table_row    (s_table_row),
        .s_table_column (s_table_column),
        .s_weight_a     (s_weight_a),
        .s_weight_b     (s_weight_b),
        .s_weight_c     (s_weight_c),
        .s_vertex_index (s_vertex_index),
        .s_g_value      (s_g_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hash_value   (m_hash_value),
        .m_over_limit   (m_over_limit)
    );

    // receiver: switches between always ready, coin toss, long stalls and a fixed rhythm
    always @(posedge aclk) begin
        rx_phase <= rx_phase + 3'd1;
        if (mode_left == 0) begin
            ready_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(20, 200);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (ready_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            2:       m_ready <= ($urandom_range(0, 7) == 0);
            default: m_ready <= (rx_phase < 3'd5);
        endcase
    end

    // result monitor, sampled at the edge so pre-edge values are seen
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_hash_value, m_over_limit);
    end

    // watchdog: too long without a transaction on either channel means a hang
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // every field random, so unused fields toggle too
    function automatic txn_t random_txn();
        txn_t it;
        it.kind         = 2'($urandom);
        it.char_value   = 8'($urandom);
        it.key_length   = 8'($urandom);
        it.class_value  = 6'($urandom);
        it.table_row    = 6'($urandom);
        it.table_column = 4'($urandom);
        it.weight_a     = 12'($urandom);
        it.weight_b     = 12'($urandom);
        it.weight_c     = 12'($urandom);
        it.vertex_index = 12'($urandom);
        it.g_value      = 12'($urandom);
        return it;
    endfunction

    // weights mostly below the vertex count, sometimes anywhere
    function automatic logic [11:0] pick_weight();
        if ($urandom_range(0, 3) == 0) return 12'($urandom);
        return 12'($urandom_range(0, int'(sb.modulus()) - 1));
    endfunction

    function automatic txn_t class_load(logic [7:0] ch, logic [5:0] cls);
        txn_t it;
        it             = random_txn();
        it.kind        = phkl_pkg::KIND_CLASS;
        it.char_value  = ch;
        it.class_value = cls;
        return it;
    endfunction

    function automatic txn_t weight_load(logic [5:0] row, logic [3:0] col,
                                         logic [11:0] wa, logic [11:0] wb, logic [11:0] wc);
        txn_t it;
        it              = random_txn();
        it.kind         = phkl_pkg::KIND_WEIGHT;
        it.table_row    = row;
        it.table_column = col;
        it.weight_a     = wa;
        it.weight_b     = wb;
        it.weight_c     = wc;
        return it;
    endfunction

    function automatic txn_t vertex_load(logic [11:0] idx, logic [11:0] val);
        txn_t it;
        it              = random_txn();
        it.kind         = phkl_pkg::KIND_VERTEX;
        it.vertex_index = idx;
        it.g_value      = val;
        return it;
    endfunction

    // drop valid once and let the sender sit idle
    task automatic hold_sender(input int cycles);
        if (valid_up) begin
            s_valid  <= 1'b0;
            valid_up = 1'b0;
        end
        repeat (cycles) @(posedge aclk);
    endtask

    // present one transaction and wait for the handshake; bursts end in a random gap
    task automatic send_txn(input txn_t it);
        s_valid        <= 1'b1;
        s_kind         <= it.kind;
        s_char_value   <= it.char_value;
        s_key_length   <= it.key_length;
        s_class_value  <= it.class_value;
        s_table_row    <= it.table_row;
        s_table_column <= it.table_column;
        s_weight_a     <= it.weight_a;
        s_weight_b     <= it.weight_b;
        s_weight_c     <= it.weight_c;
        s_vertex_index <= it.vertex_index;
        s_g_value      <= it.g_value;
        valid_up = 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(it);
        sent_items++;
        burst_left--;
        if (burst_left <= 0) begin
            hold_sender(($urandom_range(0, 4) == 0) ? $urandom_range(8, 20)
                                                     : $urandom_range(1, 4));
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                      : $urandom_range(1, 10);
        end
    endtask

    // one key character; any table entry it would read is loaded first
    task automatic send_key_char(input logic [7:0] ch, input logic [7:0] len);
        txn_t              it;
        phkl_pkg::column_t col;
        int                slot;
        key_progress_t     look;
        phkl_pkg::vertex_t u, v, w;
        if (!sb.class_set[ch])
            send_txn(class_load(ch, ($urandom_range(0, 1) == 0) ? 6'($urandom_range(0, 7))
                                                                : 6'($urandom)));
        col  = (sb.prog.left == 0) ? sb.first_column(len) : sb.prog.column;
        slot = sb.wt_slot(sb.char_class[ch], col);
        if (!sb.weight_set[slot])
            send_txn(weight_load(sb.char_class[ch], col,
                                 pick_weight(), pick_weight(), pick_weight()));
        // last character: make sure the three vertex values it will read exist
        look = sb.prog;
        if (sb.advance(look, ch, len)) begin
            sb.spread(look, u, v, w);
            if (!sb.g_set[u]) send_txn(vertex_load(u, 12'($urandom)));
            if (!sb.g_set[v]) send_txn(vertex_load(v, 12'($urandom)));
            if (!sb.g_set[w]) send_txn(vertex_load(w, 12'($urandom)));
        end
        it            = random_txn();
        it.kind       = phkl_pkg::KIND_CHAR;
        it.char_value = ch;
        it.key_length = len;
        send_txn(it);
    endtask

    // whole random key, short mostly, with stray table loads in between
    task automatic send_random_key();
        int         r;
        int         count;
        logic [7:0] len;
        txn_t       noise;
        r = $urandom_range(0, 199);
        if (r < 8) len = 8'd0;
        else if (r < 120) len = 8'($urandom_range(1, 4));
        else if (r < 180) len = 8'($urandom_range(5, 20));
        else if (r < 197) len = 8'($urandom_range(21, 60));
        else len = 8'($urandom_range(120, 255));
        count = (len == 0) ? 1 : int'(len);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                noise      = random_txn();
                noise.kind = 2'($urandom_range(1, 3));
                send_txn(noise);
            end
            send_key_char(($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                       : 8'($urandom_range(0, 23)),
                          (i == 0) ? len : 8'($urandom));
        end
    endtask

    // registers only change with the block drained and settled
    task automatic write_settings(input logic [12:0] vc, input logic [12:0] kl,
                                  input logic [12:0] cc);
        hold_sender(0);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= phkl_pkg::CFG_VERTEX_COUNT;
        cfg_wdata <= vc;
        @(posedge aclk);
        sb.write_reg(phkl_pkg::CFG_VERTEX_COUNT, vc);
        cfg_index <= phkl_pkg::CFG_KEY_LIMIT;
        cfg_wdata <= kl;
        @(posedge aclk);
        sb.write_reg(phkl_pkg::CFG_KEY_LIMIT, kl);
        cfg_index <= phkl_pkg::CFG_COLUMN_COUNT;
        cfg_wdata <= cc;
        @(posedge aclk);
        sb.write_reg(phkl_pkg::CFG_COLUMN_COUNT, cc);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int stop_at;
        int directed_end;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset settings (4096 vertices, one column)
        send_txn(class_load(8'h00, 6'h00));
        send_txn(class_load(8'hFF, 6'h3F));
        send_txn(weight_load(6'h00, 4'h0, 12'h000, 12'h000, 12'h000));
        send_txn(weight_load(6'h3F, 4'h0, 12'hFFF, 12'hFFF, 12'hFFF));
        send_txn(vertex_load(12'h000, 12'hABC));
        send_txn(vertex_load(12'hFFF, 12'h555));
        // all three sums zero, so every vertex needs separating
        send_key_char(8'h00, 8'd1);
        // zero length taken as one char; sums at the top wrap when bumped
        send_key_char(8'hFF, 8'd0);
        // two characters, sums end at the top of the range and wrap to zero when bumped
        send_key_char(8'h00, 8'd2);
        send_key_char(8'hFF, 8'hA5);

        // tiny vertex count, widest table, low key limit forces the over-limit flag
        write_settings(13'd3, 13'd1, 13'd16);
        send_txn(weight_load(6'h3F, 4'hF, 12'hFFF, 12'h000, 12'h800));
        send_key_char(8'hFF, 8'd3);
        send_key_char(8'h00, 8'd0);
        send_key_char(8'hFF, 8'd0);
        send_key_char(8'hFF, 8'd1);
        directed_end = sent_items;

        // random phases, each under its own register setting
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: write_settings(13'd5, 13'd1, 13'd2);
                1: write_settings(13'd4096, 13'd4095, 13'd1);
                2: write_settings(13'd0, 13'd2048, 13'd0);      // both clamp up to one
                3: write_settings(13'd8191, 13'd4095, 13'd31);  // both saturate
                4: write_settings(13'd4, 13'd7, 13'd5);
                default: write_settings(13'($urandom_range(3, 4096)),
                                        13'($urandom_range(1, 4095)),
                                        13'($urandom_range(1, 16)));
            endcase
            stop_at = directed_end + (p + 1) * ITEM_TARGET / NUM_PHASES;
            while (sent_items < stop_at) send_random_key();
        end

        // drain, then let any stray result show up
        hold_sender(0);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/phkl_pkg.sv
design/perfect_hash_key_lookup.sv
tb/tb.sv
